@@ rtl/ppr_pkg.sv @@
package ppr_pkg;

  // Framing position within a packet.
  typedef enum logic [2:0] {
    PH_MAGIC1      = 3'd0,
    PH_MAGIC2      = 3'd1,
    PH_COMMAND     = 3'd2,
    PH_COMPRESSION = 3'd3,
    PH_LENGTH_LO   = 3'd4,
    PH_LENGTH_HI   = 3'd5,
    PH_PAYLOAD     = 3'd6,
    PH_TRAILER     = 3'd7
  } phase_t;

  // Event codes reported on the fourth trailer byte.
  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_INIT    = 3'd1,
    EV_PRINT   = 3'd2,
    EV_STORED  = 3'd3,
    EV_DROPPED = 3'd4,
    EV_OTHER   = 3'd5
  } event_t;

  localparam logic [7:0] MAGIC_FIRST  = 8'h88;
  localparam logic [7:0] MAGIC_SECOND = 8'h33;
  localparam logic [7:0] REPLY_GOOD   = 8'h81;
  localparam logic [7:0] REPLY_NONE   = 8'h00;

  localparam logic [7:0] CMD_INIT  = 8'h01;
  localparam logic [7:0] CMD_PRINT = 8'h02;
  localparam logic [7:0] CMD_DATA  = 8'h04;

  // Trailer positions, counted after the current byte.
  localparam logic [15:0] TRAILER_CHECK = 16'd3;
  localparam logic [15:0] TRAILER_LAST  = 16'd4;

endpackage

@@ rtl/printer_packet_receiver_core.sv @@
// Printer packet receiver.
// The input channel (in_valid, in_ready, rx_byte) takes one byte from the
// host serial link per request. The block frames packets of two magic
// bytes, command, compression, 16-bit little-endian length, payload and a
// four-byte trailer, keeping a 16-bit wrapping checksum on the way.
// Every accepted byte yields exactly one result request on the output
// channel (out_valid, out_ready and the result fields): the reply byte,
// the event of the executed command, the checksum verdict, the payload
// byte with its offset, the committed slot details and the packet count.
// The result is registered: it appears in the output register in the cycle
// after the byte is accepted. Throughput is one byte per cycle while results
// are taken, set by the single state update between the input handshake and
// the output register.
// When the receiver stalls, the output register holds its result and
// in_ready falls until that result is taken; no byte is lost.
// Reset clears the framing state, the checksum, the packet count and the
// reply, and leaves the output channel empty.
module printer_packet_receiver_core
  import ppr_pkg::*;
#(
  parameter int MAX_PACKETS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  reply_byte,
  output logic [2:0]  event_res,
  output logic        checksum_ok,
  output logic        payload_valid,
  output logic [7:0]  payload_byte,
  output logic [15:0] payload_offset,
  output logic [3:0]  stored_slot,
  output logic [15:0] stored_size,
  output logic [7:0]  stored_compressed,
  output logic [4:0]  packet_count
);

  localparam logic [4:0] MaxPkts = 5'(MAX_PACKETS);

  // Framing state.
  phase_t      phase, phase_next;
  logic [7:0]  command_byte, command_byte_next;
  logic [7:0]  compression_byte, compression_byte_next;
  logic [15:0] payload_length, payload_length_next;
  logic [15:0] byte_index, byte_index_next;
  logic [15:0] running_sum, running_sum_next;
  logic [15:0] received_sum, received_sum_next;
  logic [4:0]  stored_packets, stored_packets_next;
  logic [7:0]  reply_reg, reply_reg_next;

  // Result fields before the output register.
  event_t      ev_next;
  logic        ck_next;
  logic        pv_next;
  logic [7:0]  pb_next;
  logic [15:0] po_next;
  logic [3:0]  slot_next;
  logic [15:0] size_next;
  logic [7:0]  comp_next;

  logic        in_fire;
  logic [15:0] sum_add;
  logic [15:0] index_inc;
  logic [15:0] length_full;

  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign sum_add   = running_sum + {8'h00, rx_byte};
  assign index_inc = byte_index + 16'd1;
  assign length_full = {rx_byte, payload_length[7:0]};

  // Per-byte state update and result.
  always_comb begin
    phase_next            = phase;
    command_byte_next     = command_byte;
    compression_byte_next = compression_byte;
    payload_length_next   = payload_length;
    byte_index_next       = byte_index;
    running_sum_next      = running_sum;
    received_sum_next     = received_sum;
    stored_packets_next   = stored_packets;
    reply_reg_next        = reply_reg;
    ev_next   = EV_NONE;
    ck_next   = 1'b0;
    pv_next   = 1'b0;
    pb_next   = 8'h00;
    po_next   = 16'h0000;
    slot_next = 4'h0;
    size_next = 16'h0000;
    comp_next = 8'h00;
    case (phase)
      PH_MAGIC1: begin
        reply_reg_next = REPLY_NONE;
        if (rx_byte == MAGIC_FIRST) begin
          phase_next = PH_MAGIC2;
        end
      end
      PH_MAGIC2: begin
        phase_next = (rx_byte == MAGIC_SECOND) ? PH_COMMAND : PH_MAGIC1;
      end
      PH_COMMAND: begin
        command_byte_next = rx_byte;
        running_sum_next  = {8'h00, rx_byte};
        phase_next        = PH_COMPRESSION;
      end
      PH_COMPRESSION: begin
        compression_byte_next = rx_byte;
        running_sum_next      = sum_add;
        phase_next            = PH_LENGTH_LO;
      end
      PH_LENGTH_LO: begin
        payload_length_next = {8'h00, rx_byte};
        running_sum_next    = sum_add;
        phase_next          = PH_LENGTH_HI;
      end
      PH_LENGTH_HI: begin
        payload_length_next = length_full;
        running_sum_next    = sum_add;
        byte_index_next     = 16'h0000;
        phase_next          = (length_full != 16'h0000) ? PH_PAYLOAD : PH_TRAILER;
      end
      PH_PAYLOAD: begin
        pv_next          = 1'b1;
        pb_next          = rx_byte;
        po_next          = byte_index;
        running_sum_next = sum_add;
        if (index_inc == payload_length) begin
          byte_index_next = 16'h0000;
          phase_next      = PH_TRAILER;
        end else begin
          byte_index_next = index_inc;
        end
      end
      default: begin
        // Trailer: checksum low, checksum high, then two filler bytes.
        if (byte_index == 16'd0) begin
          received_sum_next = {received_sum[15:8], rx_byte};
        end else if (byte_index == 16'd1) begin
          received_sum_next = {rx_byte, received_sum[7:0]};
        end
        byte_index_next = index_inc;
        reply_reg_next  = REPLY_NONE;
        if (index_inc == TRAILER_CHECK && running_sum == received_sum) begin
          reply_reg_next = REPLY_GOOD;
          ck_next        = 1'b1;
        end
        if (index_inc >= TRAILER_LAST) begin
          case (command_byte)
            CMD_INIT: begin
              stored_packets_next = 5'd0;
              ev_next             = EV_INIT;
            end
            CMD_PRINT: begin
              ev_next = EV_PRINT;
            end
            CMD_DATA: begin
              if (stored_packets >= MaxPkts) begin
                ev_next = EV_DROPPED;
              end else begin
                ev_next             = EV_STORED;
                slot_next           = stored_packets[3:0];
                size_next           = payload_length;
                comp_next           = compression_byte;
                stored_packets_next = stored_packets + 5'd1;
              end
            end
            default: begin
              ev_next = EV_OTHER;
            end
          endcase
          byte_index_next = 16'h0000;
          phase_next      = PH_MAGIC1;
        end
      end
    endcase
  end

  // State registers, updated only when a byte is accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_MAGIC1;
      command_byte     <= 8'h00;
      compression_byte <= 8'h00;
      payload_length   <= 16'h0000;
      byte_index       <= 16'h0000;
      running_sum      <= 16'h0000;
      received_sum     <= 16'h0000;
      stored_packets   <= 5'd0;
      reply_reg        <= REPLY_NONE;
    end else if (in_fire) begin
      phase            <= phase_next;
      command_byte     <= command_byte_next;
      compression_byte <= compression_byte_next;
      payload_length   <= payload_length_next;
      byte_index       <= byte_index_next;
      running_sum      <= running_sum_next;
      received_sum     <= received_sum_next;
      stored_packets   <= stored_packets_next;
      reply_reg        <= reply_reg_next;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      event_res         <= ev_next;
      checksum_ok       <= ck_next;
      payload_valid     <= pv_next;
      payload_byte      <= pb_next;
      payload_offset    <= po_next;
      stored_slot       <= slot_next;
      stored_size       <= size_next;
      stored_compressed <= comp_next;
    end
  end

  // The reply and the count are state in their own right and stay put
  // while a result waits, because no byte is accepted meanwhile.
  assign reply_byte   = reply_reg;
  assign packet_count = stored_packets;

  // The packet count never passes the number of slots.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stored_packets <= MaxPkts)
    else $error("packet count exceeds slot limit");

  // A command event only comes with the return to the first magic byte.
  a_event_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res != EV_NONE |-> phase == PH_MAGIC1)
    else $error("event reported outside end of packet");

  // A payload byte leaves the block in the payload or trailer phase.
  a_payload_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && payload_valid |-> phase == PH_PAYLOAD || phase == PH_TRAILER)
    else $error("payload byte outside payload");

  // A good checksum verdict always carries the good reply.
  a_reply_good: assert property (@(posedge clk) disable iff (rst)
    out_valid && checksum_ok |-> reply_byte == REPLY_GOOD)
    else $error("checksum verdict without good reply");

  // Every accepted byte gives a result on the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("accepted byte produced no result");

endmodule
